@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define PSIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is held
`define PSIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/psis_pkg.sv @@
// ----------------------------------------------------------------------------
// psis_pkg
// types, constants and helpers of the pressure sensor i2c sequencer
// ----------------------------------------------------------------------------
package psis_pkg;

  localparam int FUNC_W  = 2;
  localparam int WORD_W  = 16;
  localparam int IDX_W   = 4;
  localparam int WAIT_W  = 16;
  localparam int OVS_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CAL_WORDS = 11;
  localparam logic [IDX_W-1:0] CAL_LAST_IDX = IDX_W'(CAL_WORDS - 1);

  localparam logic [7:0] ADDR_WR       = 8'hEE;
  localparam logic [7:0] ADDR_RD       = 8'hEF;
  localparam logic [7:0] REG_CAL_FIRST = 8'hAA;
  localparam logic [7:0] REG_CTRL      = 8'hF4;
  localparam logic [7:0] REG_RESULT    = 8'hF6;
  localparam logic [7:0] CMD_TEMP      = 8'h2E;
  localparam logic [7:0] CMD_PRES      = 8'h34;

  localparam logic [OVS_W-1:0]  OVS_RST       = 2'd0;
  localparam logic [WAIT_W-1:0] CONV_WAIT_RST = 16'd40;
  localparam logic [WAIT_W-1:0] POLL_RST      = 16'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MEAS = 2'd1,
    FUNC_CAL  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVS       = 2'd0,
    CFG_CONV_WAIT = 2'd1,
    CFG_POLL      = 2'd2,
    CFG_USE_READY = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_WSTART   = 4'd1,
    ST_WADDR    = 4'd2,
    ST_WREG     = 4'd3,
    ST_WDATA    = 4'd4,
    ST_WSTOP    = 4'd5,
    ST_WAIT     = 4'd6,
    ST_RSTART   = 4'd7,
    ST_RADDR    = 4'd8,
    ST_RREG     = 4'd9,
    ST_RRESTART = 4'd10,
    ST_RADDR2   = 4'd11,
    ST_RHI      = 4'd12,
    ST_RLO      = 4'd13,
    ST_RSTOP    = 4'd14
  } step_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              word_valid;
    logic [WORD_W-1:0] word_data;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
    logic              busy_res;
  } out_item_t;

  // byte loaded into the shifter when a step is entered
  function automatic logic [7:0] tx_byte(step_t step, logic [IDX_W-1:0] cnt, logic kind,
                                         logic [OVS_W-1:0] ovs);
    logic [7:0] b;
    b = 8'd0;
    unique case (step)
      ST_WADDR, ST_RADDR: b = ADDR_WR;
      ST_WREG:            b = REG_CTRL;
      ST_WDATA:           b = (cnt == '0) ? CMD_TEMP : (CMD_PRES | {ovs, 6'd0});
      ST_RREG:            b = kind ? (REG_CAL_FIRST + {3'd0, cnt, 1'b0}) : REG_RESULT;
      ST_RADDR2:          b = ADDR_RD;
      default:            b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [WAIT_W-1:0] at_least_one(logic [WAIT_W-1:0] v);
    return (v == '0) ? WAIT_W'(1) : v;
  endfunction

endpackage

@@ sv/psis_ifs.sv @@
// ----------------------------------------------------------------------------
// psis_ifs
// tick and result channels of the pressure sensor i2c sequencer
// ----------------------------------------------------------------------------
interface psis_in_if import psis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              sda_sample;
  logic              ready_pin;

  modport source(output valid, func, sda_sample, ready_pin, input ready);
  modport sink(input valid, func, sda_sample, ready_pin, output ready);
endinterface

interface psis_out_if import psis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_pull_low;
  logic              word_valid;
  logic [WORD_W-1:0] word_data;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;
  logic              busy_res;

  modport source(output valid, scl_level, sda_pull_low, word_valid, word_data, word_index,
                 last_word, busy_res, input ready);
  modport sink(input valid, scl_level, sda_pull_low, word_valid, word_data, word_index,
               last_word, busy_res, output ready);
endinterface

@@ sv/pressure_sensor_i2c_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_i2c_sequencer_unit
// bit-banged i2c master that reads temperature, pressure and calibration words
// ----------------------------------------------------------------------------
// Every item on in_ch is one bus tick: it carries the sampled sda level, the
// sensor ready pin and a request code (tick only, measurement, calibration
// read; requests while busy are dropped). Each tick advances the i2c master by
// one pin action and yields exactly one result item with the scl and sda drive
// after that tick, plus a 16-bit word on the tick whose scl fall ends the nack
// bit of a register read. The sequencer step logic sits between the sequencer
// state registers and a one-deep result register, so the block takes one item
// every clock cycle while in_ch.ready is high, and each result is registered;
// a skid entry behind the result register lets a tick be taken while a result
// waits, and in_ch.ready drops only while both are full. Configuration writes
// on cfg_* are registered and are used at their next use (command byte or wait
// load); write them only while no request is in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pressure_sensor_i2c_sequencer_unit import psis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  psis_in_if.sink               in_ch,
  psis_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [OVS_W-1:0]  ovs_r;
  logic [WAIT_W-1:0] conv_wait_r;
  logic [WAIT_W-1:0] poll_r;
  logic              use_ready_r;

  // sequencer state
  step_t             step_r, step_nxt;
  logic [3:0]        bc_r, bc_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [IDX_W-1:0]  wcnt_r, wcnt_nxt;
  logic              kind_r, kind_nxt;
  logic              scl_r, scl_nxt;
  logic              sdal_r, sdal_nxt;

  // byte engine results
  logic       bt_rx, bt_done, bt_scl, bt_sdal;
  logic [3:0] bt_bc;
  logic [1:0] bt_ph;
  logic [7:0] bt_shift;

  logic      enter;
  out_item_t res;

  // result register and skid entry
  out_item_t main_r, skid_r;
  logic      main_v_r, skid_v_r;
  logic      acc, pop;

  assign in_ch.ready = !skid_v_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign pop = main_v_r && out_ch.ready;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovs_r       <= OVS_RST;
      conv_wait_r <= CONV_WAIT_RST;
      poll_r      <= POLL_RST;
      use_ready_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_OVS:       ovs_r       <= cfg_wdata[OVS_W-1:0];
        CFG_CONV_WAIT: conv_wait_r <= cfg_wdata[WAIT_W-1:0];
        CFG_POLL:      poll_r      <= cfg_wdata[WAIT_W-1:0];
        CFG_USE_READY: use_ready_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // one byte plus ack bit, three ticks per bit, msb first
  always_comb begin
    bt_rx    = (step_r == ST_RHI) || (step_r == ST_RLO);
    bt_done  = 1'b0;
    bt_scl   = scl_r;
    bt_sdal  = sdal_r;
    bt_bc    = bc_r;
    bt_ph    = ph_r;
    bt_shift = shift_r;
    if (bc_r < 4'd8) begin
      case (ph_r)
        2'd0: begin
          bt_sdal = bt_rx ? 1'b0 : !shift_r[7];
          bt_ph   = 2'd1;
        end
        2'd1: begin
          bt_scl = 1'b1;
          if (bt_rx) begin
            bt_shift = {shift_r[6:0], in_ch.sda_sample};
          end
          bt_ph = 2'd2;
        end
        default: begin
          bt_scl = 1'b0;
          if (!bt_rx) begin
            bt_shift = {shift_r[6:0], 1'b0};
          end
          bt_bc = bc_r + 4'd1;
          bt_ph = 2'd0;
        end
      endcase
    end else begin
      case (ph_r)
        2'd0: begin
          // master acks the high byte, nacks the low byte
          bt_sdal = (step_r == ST_RHI);
          bt_ph   = 2'd1;
        end
        2'd1: begin
          bt_scl = 1'b1;
          bt_ph  = 2'd2;
        end
        default: begin
          bt_scl  = 1'b0;
          bt_done = 1'b1;
        end
      endcase
    end
  end

  // sequencer next state and result of this tick
  always_comb begin
    step_nxt  = step_r;
    bc_nxt    = bc_r;
    ph_nxt    = ph_r;
    shift_nxt = shift_r;
    hi_nxt    = hi_r;
    wait_nxt  = wait_r;
    wcnt_nxt  = wcnt_r;
    kind_nxt  = kind_r;
    scl_nxt   = scl_r;
    sdal_nxt  = sdal_r;
    enter     = 1'b0;
    res       = '0;

    unique case (step_r)
      ST_IDLE: begin
        scl_nxt  = 1'b1;
        sdal_nxt = 1'b0;
        if (in_ch.func == FUNC_MEAS || in_ch.func == FUNC_CAL) begin
          kind_nxt = (in_ch.func == FUNC_CAL);
          wcnt_nxt = '0;
          step_nxt = (in_ch.func == FUNC_CAL) ? ST_RSTART : ST_WSTART;
          enter    = 1'b1;
        end
      end
      ST_WSTART, ST_RSTART: begin
        if (ph_r == 2'd0) begin
          sdal_nxt = 1'b1;
          ph_nxt   = 2'd1;
        end else begin
          scl_nxt  = 1'b0;
          step_nxt = (step_r == ST_WSTART) ? ST_WADDR : ST_RADDR;
          enter    = 1'b1;
        end
      end
      ST_WADDR, ST_WREG, ST_WDATA, ST_RADDR, ST_RREG, ST_RADDR2: begin
        scl_nxt   = bt_scl;
        sdal_nxt  = bt_sdal;
        bc_nxt    = bt_bc;
        ph_nxt    = bt_ph;
        shift_nxt = bt_shift;
        if (bt_done) begin
          enter = 1'b1;
          unique case (step_r)
            ST_WADDR: step_nxt = ST_WREG;
            ST_WREG:  step_nxt = ST_WDATA;
            ST_WDATA: step_nxt = ST_WSTOP;
            ST_RADDR: step_nxt = ST_RREG;
            ST_RREG:  step_nxt = ST_RRESTART;
            default:  step_nxt = ST_RHI;
          endcase
        end
      end
      ST_RHI, ST_RLO: begin
        scl_nxt   = bt_scl;
        sdal_nxt  = bt_sdal;
        bc_nxt    = bt_bc;
        ph_nxt    = bt_ph;
        shift_nxt = bt_shift;
        if (bt_done) begin
          enter = 1'b1;
          if (step_r == ST_RHI) begin
            hi_nxt   = shift_r;
            step_nxt = ST_RLO;
          end else begin
            res.word_valid = 1'b1;
            res.word_data  = {hi_r, shift_r};
            res.word_index = wcnt_r;
            res.last_word  = kind_r ? (wcnt_r >= CAL_LAST_IDX) : (wcnt_r != '0);
            step_nxt       = ST_RSTOP;
          end
        end
      end
      ST_RRESTART: begin
        case (ph_r)
          2'd0: begin
            sdal_nxt = 1'b0;
            ph_nxt   = 2'd1;
          end
          2'd1: begin
            scl_nxt = 1'b1;
            ph_nxt  = 2'd2;
          end
          2'd2: begin
            sdal_nxt = 1'b1;
            ph_nxt   = 2'd3;
          end
          default: begin
            scl_nxt  = 1'b0;
            step_nxt = ST_RADDR2;
            enter    = 1'b1;
          end
        endcase
      end
      ST_WSTOP, ST_RSTOP: begin
        case (ph_r)
          2'd0: begin
            sdal_nxt = 1'b1;
            ph_nxt   = 2'd1;
          end
          2'd1: begin
            scl_nxt = 1'b1;
            ph_nxt  = 2'd2;
          end
          default: begin
            sdal_nxt = 1'b0;
            enter    = 1'b1;
            if (step_r == ST_WSTOP) begin
              step_nxt = ST_WAIT;
              wait_nxt = at_least_one(use_ready_r ? poll_r : conv_wait_r);
            end else if (kind_r) begin
              if (wcnt_r >= CAL_LAST_IDX) begin
                step_nxt = ST_IDLE;
              end else begin
                wcnt_nxt = wcnt_r + IDX_W'(1);
                step_nxt = ST_RSTART;
              end
            end else if (wcnt_r == '0) begin
              // temperature done, go on with the pressure command
              wcnt_nxt = IDX_W'(1);
              step_nxt = ST_WSTART;
            end else begin
              step_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_WAIT: begin
        if (wait_r > WAIT_W'(1)) begin
          wait_nxt = wait_r - WAIT_W'(1);
        end else if (!use_ready_r || in_ch.ready_pin) begin
          wait_nxt = '0;
          step_nxt = ST_RSTART;
          enter    = 1'b1;
        end else begin
          // not ready yet, start another poll period
          wait_nxt = at_least_one(poll_r);
        end
      end
      default: begin
        scl_nxt  = 1'b1;
        sdal_nxt = 1'b0;
        step_nxt = ST_IDLE;
        enter    = 1'b1;
      end
    endcase

    if (enter) begin
      bc_nxt    = '0;
      ph_nxt    = '0;
      shift_nxt = tx_byte(step_nxt, wcnt_nxt, kind_nxt, ovs_r);
    end

    res.scl_level    = scl_nxt;
    res.sda_pull_low = sdal_nxt;
    res.busy_res     = (step_nxt != ST_IDLE);
  end

  // sequencer registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      bc_r    <= '0;
      ph_r    <= '0;
      shift_r <= '0;
      hi_r    <= '0;
      wait_r  <= '0;
      wcnt_r  <= '0;
      kind_r  <= 1'b0;
      scl_r   <= 1'b1;
      sdal_r  <= 1'b0;
    end else if (acc) begin
      step_r  <= step_nxt;
      bc_r    <= bc_nxt;
      ph_r    <= ph_nxt;
      shift_r <= shift_nxt;
      hi_r    <= hi_nxt;
      wait_r  <= wait_nxt;
      wcnt_r  <= wcnt_nxt;
      kind_r  <= kind_nxt;
      scl_r   <= scl_nxt;
      sdal_r  <= sdal_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      main_v_r <= skid_v_r || acc;
      skid_v_r <= 1'b0;
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (acc) begin
        main_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = main_v_r;
  assign out_ch.scl_level    = main_r.scl_level;
  assign out_ch.sda_pull_low = main_r.sda_pull_low;
  assign out_ch.word_valid   = main_r.word_valid;
  assign out_ch.word_data    = main_r.word_data;
  assign out_ch.word_index   = main_r.word_index;
  assign out_ch.last_word    = main_r.last_word;
  assign out_ch.busy_res     = main_r.busy_res;

  // skid entry only fills behind a held result
  `PSIS_ASSERT_IMP(a_skid_behind_main, clk, rst_n, skid_v_r, main_v_r)
  `PSIS_ASSERT_NXT(a_skid_fill_cause, clk, rst_n, acc && main_v_r && !out_ch.ready, skid_v_r)
  // bus is released whenever the sequencer rests
  `PSIS_ASSERT_IMP(a_idle_bus_free, clk, rst_n, step_r == ST_IDLE, scl_r && !sdal_r)
  // a finished word always leaves the stop condition still to come
  `PSIS_ASSERT_IMP(a_word_then_busy, clk, rst_n, acc && res.word_valid,
                   res.busy_res && step_nxt == ST_RSTOP)

endmodule
